/* src/rgbconv_pkg.sv */
// shared types and constants of the rgb 3x3 convolution block
package rgbconv_pkg;

	localparam int CHAN_W        = 8;
	localparam int PIX_W         = 3 * CHAN_W;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int ROW_W         = 12;
	localparam int IMG_W_W       = 11;
	localparam int IMG_H_W       = 13;
	localparam int COEF_W        = 16;
	localparam int KROW_W        = 3 * COEF_W;
	localparam int PROD_W        = 24;
	localparam int SUM_W         = 28;
	localparam int FRAC_BITS     = 8;

	// largest value of one color channel
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROW_TOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROW_MID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROW_BOT = 3'd4;

	// register reset values
	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
	localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd1024;
	localparam logic [KROW_W-1:0]  KROW_ZERO_RST    = 48'h0000_0000_0000;
	localparam logic [KROW_W-1:0]  KROW_IDENT_RST   = 48'h0000_0100_0000;

	typedef struct packed {
		logic [CHAN_W-1:0] pix_red;
		logic [CHAN_W-1:0] pix_green;
		logic [CHAN_W-1:0] pix_blue;
	} pix_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic              run_last;
		logic              frame_done;
	} res_t;

endpackage

/* src/rgb_3x3_convolution.sv */
// rgb 3x3 convolution with clamp-to-edge borders over a raster pixel stream
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  pix     | pix_valid/pix_ready  | pix (pixel, raster order)
//  res     | res_valid/res_ready  | res (filtered pixel, run_last, frame_done)
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// One pixel per cycle while each input yields at most one result and res is
// not stalled; an input at the last column yields two, and in the last row two
// or four, and holds the input side until the single output port takes them.
// A pixel's result passes the stage 1, stage 2, stage 3 and output registers.
// Reset clears counters, window and pipeline; the two line memories are not
// cleared and need no clearing pass. A stall on res backs up through the
// ready chain to pix_ready, combinationally once every stage is occupied.
module rgb_3x3_convolution #(
	parameter int MAX_WIDTH = rgbconv_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_ready,
	input  rgbconv_pkg::pix_t                  pix,
	output logic                               res_valid,
	input  logic                               res_ready,
	output rgbconv_pkg::res_t                  res,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rgbconv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbconv_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rgbconv_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

	// configuration registers
	logic [IMG_W_W-1:0] image_width_q;
	logic [IMG_H_W-1:0] image_height_q;
	logic [KROW_W-1:0]  kern_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			kern_q[0]      <= KROW_ZERO_RST;
			kern_q[1]      <= KROW_IDENT_RST;
			kern_q[2]      <= KROW_ZERO_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:    image_width_q  <= cfg_data[IMG_W_W-1:0];
				CFG_IMAGE_HEIGHT:   image_height_q <= cfg_data[IMG_H_W-1:0];
				CFG_KERNEL_ROW_TOP: kern_q[0]      <= cfg_data[KROW_W-1:0];
				CFG_KERNEL_ROW_MID: kern_q[1]      <= cfg_data[KROW_W-1:0];
				CFG_KERNEL_ROW_BOT: kern_q[2]      <= cfg_data[KROW_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size and clamped position of the incoming pixel
	logic [WW-1:0]      w_eff, w_m1, w_raw;
	logic [IMG_H_W-1:0] h_eff, h_m1;
	logic [CW-1:0]      col_q, c_cur;
	logic [ROW_W-1:0]   row_q, r_cur;
	logic               c_last, r_last;

	always_comb begin
		w_raw = WW'(image_width_q);
		if (w_raw < WW'(2))
			w_eff = WW'(2);
		else if (w_raw > WW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = w_raw;
		w_m1 = w_eff - WW'(1);

		if (image_height_q < IMG_H_W'(2))
			h_eff = IMG_H_W'(2);
		else if (image_height_q > IMG_H_W'(MAX_HEIGHT))
			h_eff = IMG_H_W'(MAX_HEIGHT);
		else
			h_eff = image_height_q;
		h_m1 = h_eff - IMG_H_W'(1);

		c_cur  = (WW'(col_q) >= w_eff) ? w_m1[CW-1:0] : col_q;
		r_cur  = (IMG_H_W'(row_q) >= h_eff) ? h_m1[ROW_W-1:0] : row_q;
		c_last = (WW'(c_cur) == w_m1);
		r_last = (IMG_H_W'(r_cur) == h_m1);
	end

	// pipeline handshake chain, from the output back to the input
	logic       pix_accept;
	logic       valid_s1, s1_adv, s2_free, issue_s2, rdy_s3, rdy_o;
	logic       valid_s3, res_valid_q;
	logic [3:0] mask_s2, mask_nxt, pick;

	assign rdy_o      = !res_valid_q || res_ready;
	assign rdy_s3     = !valid_s3 || rdy_o;
	assign issue_s2   = (mask_s2 != 4'd0) && rdy_s3;
	assign s2_free    = (mask_s2 == 4'd0) || (issue_s2 && (mask_nxt == 4'd0));
	assign s1_adv     = valid_s1 && s2_free;
	assign pix_ready  = !valid_s1 || s1_adv;
	assign pix_accept = pix_valid && pix_ready;

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_accept) begin
			if (c_last) begin
				col_q <= '0;
				row_q <= r_last ? '0 : r_cur + ROW_W'(1);
			end else begin
				col_q <= c_cur + CW'(1);
				row_q <= r_cur;
			end
		end
	end

	// line memories: read on accept, written back when the pixel leaves s1
	logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0] up_rd_s1, mid_rd_s1;
	logic [CW-1:0]    addr_s1;
	pix_t             pix_s1;
	logic             emit_s1, first_row_s1, first_col_s1, last_row_s1, last_col_s1;

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			up_rd_s1  <= upper_mem[c_cur];
			mid_rd_s1 <= middle_mem[c_cur];
		end
		if (s1_adv) begin
			upper_mem[addr_s1]  <= mid_rd_s1;
			middle_mem[addr_s1] <= pix_s1;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pix_ready)
			valid_s1 <= pix_valid;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (pix_accept) begin
			pix_s1       <= pix;
			addr_s1      <= c_cur;
			emit_s1      <= (r_cur != '0) && (c_cur != '0);
			first_row_s1 <= (r_cur == ROW_W'(1));
			first_col_s1 <= (c_cur == CW'(1));
			last_row_s1  <= r_last;
			last_col_s1  <= c_last;
		end
	end

	// 3x3 window, shifted as each pixel enters stage 2
	pix_t win_q [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++)
				win_q[k] <= '0;
		end else if (s1_adv) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= up_rd_s1;
			win_q[5] <= mid_rd_s1;
			win_q[8] <= pix_s1;
		end
	end

	// stage 2 sequencer: one pending bit per result of the pixel
	// bit 0 own column, bit 1 right edge, bit 2 last row, bit 3 frame corner
	logic       first_row_s2, first_col_s2;
	logic [1:0] sel;

	always_comb begin
		if (mask_s2[0]) begin
			pick = 4'b0001;
			sel  = 2'd0;
		end else if (mask_s2[1]) begin
			pick = 4'b0010;
			sel  = 2'd1;
		end else if (mask_s2[2]) begin
			pick = 4'b0100;
			sel  = 2'd2;
		end else begin
			pick = 4'b1000;
			sel  = 2'd3;
		end
		mask_nxt = mask_s2 & ~pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mask_s2 <= 4'd0;
		else if (s1_adv)
			mask_s2 <= emit_s1 ? {last_row_s1 && last_col_s1, last_row_s1, last_col_s1, 1'b1}
			                   : 4'd0;
		else if (issue_s2)
			mask_s2 <= mask_nxt;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			first_row_s2 <= first_row_s1;
			first_col_s2 <= first_col_s1;
		end
	end

	// clamped row and column taps of the window
	logic [1:0]       rsel [3];
	logic [1:0]       csel [3];
	logic [PIX_W-1:0] tap  [3][3];

	always_comb begin
		if (sel[1]) begin
			rsel[0] = 2'd1; rsel[1] = 2'd2; rsel[2] = 2'd2;
		end else if (first_row_s2) begin
			rsel[0] = 2'd1; rsel[1] = 2'd1; rsel[2] = 2'd2;
		end else begin
			rsel[0] = 2'd0; rsel[1] = 2'd1; rsel[2] = 2'd2;
		end
		if (sel[0]) begin
			csel[0] = 2'd1; csel[1] = 2'd2; csel[2] = 2'd2;
		end else if (first_col_s2) begin
			csel[0] = 2'd1; csel[1] = 2'd1; csel[2] = 2'd2;
		end else begin
			csel[0] = 2'd0; csel[1] = 2'd1; csel[2] = 2'd2;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				tap[i][j] = win_q[4'({2'b00, rsel[i]}) * 4'd3 + 4'({2'b00, csel[j]})];
	end

	// stage 3: products of each channel tap with its coefficient
	logic signed [PROD_W:0]   mul_c  [3][3][3];
	logic signed [PROD_W-1:0] prod_s3 [3][3][3];
	logic                     last_s3, done_s3;

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					mul_c[ch][i][j] = $signed({1'b0, tap[i][j][(2-ch)*CHAN_W +: CHAN_W]})
					                * $signed(kern_q[i][j*COEF_W +: COEF_W]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (rdy_s3)
			valid_s3 <= issue_s2;
	end

	always_ff @(posedge clk) begin
		if (issue_s2) begin
			for (int ch = 0; ch < 3; ch++)
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						prod_s3[ch][i][j] <= mul_c[ch][i][j][PROD_W-1:0];
			last_s3 <= (mask_nxt == 4'd0);
			done_s3 <= (sel == 2'd3);
		end
	end

	// output stage: sum, floor shift and saturation per channel
	logic signed [SUM_W-1:0] sum_c [3];
	logic signed [SUM_W-1:0] q_c   [3];
	logic [CHAN_W-1:0]       sat_c [3];
	res_t                    res_q;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_c[ch] = '0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					sum_c[ch] = sum_c[ch] + SUM_W'(prod_s3[ch][i][j]);
			q_c[ch] = sum_c[ch] >>> FRAC_BITS;
			if (q_c[ch] < 0)
				sat_c[ch] = '0;
			else if (q_c[ch] > $signed(SUM_W'(CHAN_MAX)))
				sat_c[ch] = CHAN_MAX;
			else
				sat_c[ch] = q_c[ch][CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (rdy_o)
			res_valid_q <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_o && valid_s3) begin
			res_q.out_red    <= sat_c[0];
			res_q.out_green  <= sat_c[1];
			res_q.out_blue   <= sat_c[2];
			res_q.run_last   <= last_s3;
			res_q.frame_done <= done_s3;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// the frame corner result always closes the run of its pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_done |-> res.run_last)
		else $error("frame_done without run_last");

	// a read never hits the line entry written back in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_accept && s1_adv |-> c_cur != addr_s1)
		else $error("line memory read and write collide");

	// a pixel held in stage 1 is not dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1)
		else $error("stage 1 pixel lost");

endmodule

/* tb/testbench.sv */
// self-checking testbench for the rgb 3x3 convolution block with a pixel-level predictor
`timescale 1ns / 1ps

module testbench;
	import rgbconv_pkg::*;

	localparam int MAX_W         = MAX_WIDTH_DEF;
	localparam int CYCLE_LIMIT   = 1200000;
	localparam int RANDOM_PIXELS = 230;
	localparam int SETTLE_CYCLES = 8;
	localparam int SHOWN_ERRORS  = 10;

	// unmapped register indexes, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// q8.8 coefficients used by the directed frames
	localparam logic [COEF_W-1:0] COEF_POS_MAX   = 16'h7FFF;
	localparam logic [COEF_W-1:0] COEF_NEG_MAX   = 16'h8000;
	localparam logic [COEF_W-1:0] COEF_ONE       = 16'h0100;
	localparam logic [COEF_W-1:0] COEF_MINUS_ONE = 16'hFF00;
	localparam logic [COEF_W-1:0] COEF_EIGHT     = 16'h0800;

	// which three window rows or columns feed one output
	typedef enum logic [1:0] {SPAN_MID, SPAN_LOW_EDGE, SPAN_HIGH_EDGE} span_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pix_t                  pix       = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_t                  res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor copy of registers, line stores, window and raster position
	logic [IMG_W_W-1:0] img_width   = IMAGE_WIDTH_RST;
	logic [IMG_H_W-1:0] img_height  = IMAGE_HEIGHT_RST;
	logic [KROW_W-1:0]  kernel [3]  = '{KROW_ZERO_RST, KROW_IDENT_RST, KROW_ZERO_RST};
	logic [PIX_W-1:0]   upper_line [MAX_W] = '{default: '0};
	logic [PIX_W-1:0]   middle_line [MAX_W] = '{default: '0};
	logic [PIX_W-1:0]   win [9] = '{default: '0};
	int                 col_pos = 0;
	int                 row_pos = 0;

	pix_t pending_pixels [$];
	res_t expected_filtered [$];

	int pixels_queued = 0;
	int pixels_in     = 0;
	int checked       = 0;
	int mismatches    = 0;
	int cycles        = 0;
	int pix_gap       = 0;
	int pix_calm      = 0;
	int res_hold      = 0;
	int res_calm      = 0;

	rgb_3x3_convolution DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always #10 clk = ~clk;

	// idle length: mostly none or short, a few long, with calm stretches of none
	function automatic int pick_gap(inout int calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (roll < 4) begin
			calm = $urandom_range(16, 64);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	// window row or column feeding tap i, with edge clamping
	function automatic int tap(span_t s, int i);
		case (s)
			SPAN_LOW_EDGE:  return (i == 0) ? 1 : i;
			SPAN_HIGH_EDGE: return (i == 0) ? 1 : 2;
			default:        return i;
		endcase
	endfunction

	// one channel: signed q8.8 sum, floor shift, saturate
	function automatic logic [CHAN_W-1:0] conv_channel(span_t rs, span_t cs, int lsb);
		int          acc;
		int          q;
		int          pv;
		int          cf;
		logic [PIX_W-1:0] px;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				px = win[tap(rs, i) * 3 + tap(cs, j)];
				pv = int'(px >> lsb) & 255;
				cf = int'($signed(kernel[i][COEF_W*j +: COEF_W]));
				acc += pv * cf;
			end
		end
		q = acc >>> FRAC_BITS;
		if (q < 0)
			q = 0;
		if (q > int'(CHAN_MAX))
			q = int'(CHAN_MAX);
		return q[CHAN_W-1:0];
	endfunction

	function automatic res_t filtered_pixel(span_t rs, span_t cs, logic done);
		res_t o;
		o.out_red    = conv_channel(rs, cs, 2 * CHAN_W);
		o.out_green  = conv_channel(rs, cs, CHAN_W);
		o.out_blue   = conv_channel(rs, cs, 0);
		o.run_last   = 1'b0;
		o.frame_done = done;
		return o;
	endfunction

	// register write as the block applies it
	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_IMAGE_WIDTH:    img_width  = val[IMG_W_W-1:0];
			CFG_IMAGE_HEIGHT:   img_height = val[IMG_H_W-1:0];
			CFG_KERNEL_ROW_TOP: kernel[0]  = val[KROW_W-1:0];
			CFG_KERNEL_ROW_MID: kernel[1]  = val[KROW_W-1:0];
			CFG_KERNEL_ROW_BOT: kernel[2]  = val[KROW_W-1:0];
			default: ;
		endcase
	endtask

	// accept one raster pixel and queue the outputs it completes
	task automatic advance_raster(input pix_t p);
		int    w;
		int    h;
		int    c;
		int    r;
		int    n;
		res_t  outs [4];
		span_t rs;
		span_t cs;
		w = img_width;
		if (w < 2)
			w = 2;
		if (w > MAX_W)
			w = MAX_W;
		h = img_height;
		if (h < 2)
			h = 2;
		if (h > MAX_HEIGHT)
			h = MAX_HEIGHT;
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;

		// slide the window and rotate the line stores
		for (int k = 0; k < 3; k++) begin
			win[k * 3]     = win[k * 3 + 1];
			win[k * 3 + 1] = win[k * 3 + 2];
		end
		win[2] = upper_line[c];
		win[5] = middle_line[c];
		win[8] = p;
		upper_line[c]  = middle_line[c];
		middle_line[c] = p;

		// raster-order outputs, last two rows interleaved
		if (r >= 1 && c >= 1) begin
			rs = (r == 1) ? SPAN_LOW_EDGE : SPAN_MID;
			cs = (c == 1) ? SPAN_LOW_EDGE : SPAN_MID;
			n = 0;
			outs[n] = filtered_pixel(rs, cs, 1'b0);
			n++;
			if (c == w - 1) begin
				outs[n] = filtered_pixel(rs, SPAN_HIGH_EDGE, 1'b0);
				n++;
			end
			if (r == h - 1) begin
				outs[n] = filtered_pixel(SPAN_HIGH_EDGE, cs, 1'b0);
				n++;
				if (c == w - 1) begin
					outs[n] = filtered_pixel(SPAN_HIGH_EDGE, SPAN_HIGH_EDGE, 1'b1);
					n++;
				end
			end
			outs[n - 1].run_last = 1'b1;
			for (int k = 0; k < n; k++)
				expected_filtered.push_back(outs[k]);
		end

		// raster position
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// pixel driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_valid && pix_ready) begin
				advance_raster(pix);
				pixels_in++;
			end
			if (!pix_valid || pix_ready) begin
				if (pix_gap > 0) begin
					pix_gap--;
					pix_valid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					pix       <= pending_pixels.pop_front();
					pix_valid <= 1'b1;
					pix_gap = pick_gap(pix_calm);
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_filtered.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("unexpected result r=%0d g=%0d b=%0d last=%0b done=%0b",
							res.out_red, res.out_green, res.out_blue,
							res.run_last, res.frame_done);
				end else begin
					want = expected_filtered.pop_front();
					checked++;
					if (res.out_red !== want.out_red || res.out_green !== want.out_green
							|| res.out_blue !== want.out_blue
							|| res.run_last !== want.run_last
							|| res.frame_done !== want.frame_done) begin
						mismatches++;
						if (mismatches <= SHOWN_ERRORS) begin
							$display("mismatch %0d: want r=%0d g=%0d b=%0d last=%0b done=%0b",
								checked, want.out_red, want.out_green, want.out_blue,
								want.run_last, want.frame_done);
							$display("  got r=%0d g=%0d b=%0d last=%0b done=%0b",
								res.out_red, res.out_green, res.out_blue,
								res.run_last, res.frame_done);
						end
					end
				end
			end
			if (res_hold > 0) begin
				res_hold--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				res_hold = pick_gap(res_calm);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("rgb_3x3_convolution test failed");
			$finish;
		end
	end

	// register write, valid left high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_register(idx, val);
	endtask

	task automatic queue_pixel(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
			input logic [CHAN_W-1:0] blue);
		pix_t p;
		p.pix_red   = red;
		p.pix_green = green;
		p.pix_blue  = blue;
		pending_pixels.push_back(p);
		pixels_queued++;
	endtask

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return CHAN_MAX;
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	task automatic queue_random(input int count);
		for (int k = 0; k < count; k++)
			queue_pixel(rand_chan(), rand_chan(), rand_chan());
	endtask

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 7))
			0:       return COEF_POS_MAX;
			1:       return COEF_NEG_MAX;
			2:       return COEF_ONE;
			3:       return COEF_W'($urandom);
			default: return COEF_W'($urandom_range(0, 640) - 320);
		endcase
	endfunction

	function automatic logic [KROW_W-1:0] rand_kernel_row();
		return {rand_coef(), rand_coef(), rand_coef()};
	endfunction

	// wait until every pixel is in and every output is out, then let the pipe drain
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pixels_in != pixels_queued || expected_filtered.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// stimulus sequence
	initial begin
		int                    w_code;
		int                    h_code;
		int                    frames;
		int                    random_pixels;
		logic [CFG_DATA_W-1:0] junk;
		frames = 0;
		random_pixels = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset kernel is the identity: a 3x2 frame comes back unchanged
		write_reg(CFG_IMAGE_WIDTH, 48'd3);
		write_reg(CFG_IMAGE_HEIGHT, 48'd2);
		write_reg(CFG_SPARE_LO, CFG_DATA_W'({$urandom, $urandom}));
		write_reg(CFG_SPARE_HI, '1);
		cfg_valid <= 1'b0;
		queue_pixel(8'd255, 8'd0, 8'd255);
		queue_pixel(8'd0, 8'd255, 8'd0);
		queue_pixel(8'd128, 8'd127, 8'd1);
		queue_pixel(8'd1, 8'd254, 8'd128);
		queue_pixel(8'd0, 8'd0, 8'd0);
		queue_pixel(8'd255, 8'd255, 8'd255);
		wait_idle();
		frames++;

		// sizes below the minimum, coefficients at the positive end
		write_reg(CFG_IMAGE_WIDTH, 48'hFFFF_FFFF_F800);
		write_reg(CFG_IMAGE_HEIGHT, 48'h0000_0000_0001);
		write_reg(CFG_KERNEL_ROW_TOP, {3{COEF_POS_MAX}});
		write_reg(CFG_KERNEL_ROW_MID, {3{COEF_POS_MAX}});
		write_reg(CFG_KERNEL_ROW_BOT, {3{COEF_POS_MAX}});
		cfg_valid <= 1'b0;
		queue_pixel(8'd1, 8'd0, 8'd255);
		queue_pixel(8'd255, 8'd128, 8'd0);
		queue_pixel(8'd0, 8'd0, 8'd0);
		queue_pixel(8'd2, 8'd255, 8'd7);
		wait_idle();

		// same 2x2 frame with coefficients at the negative end
		write_reg(CFG_KERNEL_ROW_TOP, {3{COEF_NEG_MAX}});
		write_reg(CFG_KERNEL_ROW_MID, {3{COEF_NEG_MAX}});
		write_reg(CFG_KERNEL_ROW_BOT, {3{COEF_NEG_MAX}});
		cfg_valid <= 1'b0;
		queue_pixel(8'd255, 8'd255, 8'd255);
		queue_pixel(8'd0, 8'd0, 8'd0);
		queue_pixel(8'd0, 8'd1, 8'd2);
		queue_pixel(8'd200, 8'd100, 8'd50);
		wait_idle();
		frames += 2;

		// tall frame with a laplacian, then both sizes lowered past the counters
		write_reg(CFG_IMAGE_WIDTH, 48'd3);
		write_reg(CFG_IMAGE_HEIGHT, 48'h1FFF);
		write_reg(CFG_KERNEL_ROW_TOP, {3{COEF_MINUS_ONE}});
		write_reg(CFG_KERNEL_ROW_MID, {COEF_MINUS_ONE, COEF_EIGHT, COEF_MINUS_ONE});
		write_reg(CFG_KERNEL_ROW_BOT, {3{COEF_MINUS_ONE}});
		cfg_valid <= 1'b0;
		queue_random(11);
		wait_idle();
		write_reg(CFG_IMAGE_WIDTH, 48'd2);
		write_reg(CFG_IMAGE_HEIGHT, 48'd2);
		cfg_valid <= 1'b0;
		queue_random(1);
		wait_idle();
		frames++;

		// small random frames with random kernels and junk in unused register bits
		while (random_pixels < RANDOM_PIXELS) begin
			w_code = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
			h_code = $urandom_range(0, 6);
			junk = CFG_DATA_W'({$urandom, $urandom});
			junk[IMG_W_W-1:0] = IMG_W_W'(w_code);
			write_reg(CFG_IMAGE_WIDTH, junk);
			junk = CFG_DATA_W'({$urandom, $urandom});
			junk[IMG_H_W-1:0] = IMG_H_W'(h_code);
			write_reg(CFG_IMAGE_HEIGHT, junk);
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_KERNEL_ROW_TOP, rand_kernel_row());
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_KERNEL_ROW_MID, rand_kernel_row());
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_KERNEL_ROW_BOT, rand_kernel_row());
			cfg_valid <= 1'b0;
			if (w_code < 2)
				w_code = 2;
			if (h_code < 2)
				h_code = 2;
			queue_random(w_code * h_code);
			random_pixels += w_code * h_code;
			frames++;
			wait_idle();
		end

		mismatches += expected_filtered.size();
		$display("ran %0d pixels in %0d frames of 2 to 9 columns, %0d outputs checked",
			pixels_in, frames, checked);
		$display("identity, extreme, laplacian and random kernels; sizes clamped and lowered");
		if (mismatches == 0)
			$display("rgb_3x3_convolution test passed");
		else
			$display("rgb_3x3_convolution test failed");
		$finish;
	end

endmodule

/* sim.f */
src/rgbconv_pkg.sv
src/rgb_3x3_convolution.sv
tb/testbench.sv
